@@ hw/rtl/led_matrix_column_scanner_macros.svh @@
// Assertion shorthands shared by the scanner RTL.
// Each one is clocked on clk and switched off while rst_n is low.
`ifndef LED_MATRIX_COLUMN_SCANNER_MACROS_SVH
`define LED_MATRIX_COLUMN_SCANNER_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define LMCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge out of reset.
`define LMCS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/lmcs_pkg.sv @@
package lmcs_pkg;

  // Matrix geometry and timing
  localparam int COLUMNS = 10;
  localparam int COL_W   = 4;
  localparam logic [15:0] START_DELAY = 16'd11;

  // Port bytes
  localparam logic [7:0] STROBE_BYTE = 8'h80;
  localparam logic [7:0] HALT_BYTE   = 8'h00;

  // Register reset values
  localparam logic [9:0] RESET_DELAY_STEP  = 10'd10;
  localparam logic [9:0] RESET_DELAY_FLOOR = 10'd1;

  // Result queue sizing (depth is a power of two)
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  localparam int MAX_RESULTS = 3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SLOWER = 3'd2,
    OP_FASTER = 3'd3,
    OP_STOP   = 3'd4
  } op_t;

  typedef enum logic {
    CFG_DELAY_STEP  = 1'b0,
    CFG_DELAY_FLOOR = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       port_write;
    logic [7:0] port_byte;
    logic       frame_done;
    logic       load_refused;
    logic       last;
  } result_t;

  // Results produced by one item, packed from slot 0
  typedef struct packed {
    logic [1:0]    count;
    result_t [2:0] res;
  } push_t;

endpackage

@@ hw/rtl/lmcs_core.sv @@
module lmcs_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  lmcs_pkg::item_t          item,
  input  logic                     cfg_wr_en,
  input  lmcs_pkg::cfg_idx_t       cfg_index,
  input  logic [9:0]               cfg_wdata,
  output lmcs_pkg::push_t          push
);
  import lmcs_pkg::*;

  // Scanner state
  logic [7:0]       store_r [2][COLUMNS];
  logic             shown_r, shown_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] fill_r, fill_nxt;
  logic             pending_r, pending_nxt;
  logic [15:0]      delay_r, delay_nxt;
  logic [15:0]      wait_r, wait_nxt;
  logic             first_r, first_nxt;
  logic             running_r, running_nxt;
  logic             halted_r, halted_nxt;
  logic [9:0]       step_r;
  logic [9:0]       min_r;

  // Store write request
  logic             st_we;
  logic [COL_W-1:0] st_col;

  // Datapath helpers
  logic             last_col;
  logic             halt_now;
  logic [7:0]       col_byte;
  logic [16:0]      slow_sum;
  logic [16:0]      fast_floor;
  logic             refused;
  result_t          strobe_res, col_res, halt_res;

  assign last_col   = (col_r == COL_W'(COLUMNS - 1));
  assign halt_now   = last_col && !running_r;
  assign col_byte   = {1'b0, store_r[shown_r][col_r][6:0]};
  assign slow_sum   = {1'b0, delay_r} + 17'(step_r);
  assign fast_floor = 17'(step_r) + 17'(min_r);
  assign refused    = pending_r || !running_r || halted_r;

  always_comb begin
    strobe_res = '{port_write: 1'b1, port_byte: STROBE_BYTE, frame_done: 1'b0,
                   load_refused: 1'b0, last: 1'b0};
    col_res    = '{port_write: 1'b1, port_byte: col_byte,
                   frame_done: last_col && running_r, load_refused: 1'b0,
                   last: !halt_now};
    halt_res   = '{port_write: 1'b1, port_byte: HALT_BYTE, frame_done: 1'b1,
                   load_refused: 1'b0, last: 1'b1};
  end

  // Next state and results for the item in the input register
  always_comb begin
    shown_nxt   = shown_r;
    col_nxt     = col_r;
    fill_nxt    = fill_r;
    pending_nxt = pending_r;
    delay_nxt   = delay_r;
    wait_nxt    = wait_r;
    first_nxt   = first_r;
    running_nxt = running_r;
    halted_nxt  = halted_r;
    st_we       = 1'b0;
    st_col      = fill_r;
    push        = '0;
    if (go) begin
      case (op_t'(item.operation))
        OP_TICK: begin
          if (!halted_r) begin
            if (wait_r != 16'd0) begin
              wait_nxt = wait_r - 16'd1;
            end else begin
              wait_nxt  = (delay_r != 16'd0) ? delay_r - 16'd1 : 16'd0;
              first_nxt = 1'b0;
              col_nxt   = col_r + COL_W'(1);
              if (last_col) begin
                if (!running_r) begin
                  halted_nxt = 1'b1;
                end else begin
                  col_nxt = '0;
                  if (pending_r) begin
                    shown_nxt   = !shown_r;
                    pending_nxt = 1'b0;
                    fill_nxt    = '0;
                  end
                end
              end
              // Strobe is skipped on the first column after reset
              if (first_r) begin
                push.res[0] = col_res;
                push.res[1] = halt_res;
                push.count  = halt_now ? 2'd2 : 2'd1;
              end else begin
                push.res[0] = strobe_res;
                push.res[1] = col_res;
                push.res[2] = halt_res;
                push.count  = halt_now ? 2'd3 : 2'd2;
              end
            end
          end
        end
        OP_LOAD: begin
          push.count  = 2'd1;
          push.res[0] = '{port_write: 1'b0, port_byte: 8'h00, frame_done: 1'b0,
                          load_refused: 1'b1, last: 1'b1};
          if (!refused) begin
            if (fill_r < COL_W'(COLUMNS)) begin
              st_we    = 1'b1;
              fill_nxt = fill_r + COL_W'(1);
              push.res[0].load_refused = 1'b0;
            end
            // Mark closes the frame even when the byte itself is overfull
            if (item.last_byte) begin
              pending_nxt = 1'b1;
              fill_nxt    = '0;
            end
          end
        end
        OP_SLOWER: begin
          delay_nxt = slow_sum[16] ? 16'hFFFF : slow_sum[15:0];
        end
        OP_FASTER: begin
          if ({1'b0, delay_r} >= fast_floor) begin
            delay_nxt = delay_r - 16'(step_r);
          end else begin
            delay_nxt = 16'(min_r);
          end
        end
        OP_STOP: begin
          running_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r   <= 1'b0;
      col_r     <= '0;
      fill_r    <= '0;
      pending_r <= 1'b0;
      delay_r   <= START_DELAY;
      wait_r    <= 16'd0;
      first_r   <= 1'b1;
      running_r <= 1'b1;
      halted_r  <= 1'b0;
    end else begin
      shown_r   <= shown_nxt;
      col_r     <= col_nxt;
      fill_r    <= fill_nxt;
      pending_r <= pending_nxt;
      delay_r   <= delay_nxt;
      wait_r    <= wait_nxt;
      first_r   <= first_nxt;
      running_r <= running_nxt;
      halted_r  <= halted_nxt;
    end
  end

  // Frame store: both halves clear at reset, loads fill the hidden half
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int h = 0; h < 2; h++) begin
        for (int c = 0; c < COLUMNS; c++) begin
          store_r[h][c] <= 8'h00;
        end
      end
    end else if (st_we) begin
      store_r[!shown_r][st_col] <= item.data_byte;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= RESET_DELAY_STEP;
      min_r  <= RESET_DELAY_FLOOR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DELAY_STEP:  step_r <= cfg_wdata;
        CFG_DELAY_FLOOR: min_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

`include "led_matrix_column_scanner_macros.svh"

  `LMCS_ASSERT_NEVER(a_fill_range, fill_r > COL_W'(COLUMNS), "fill index past column count")
  `LMCS_ASSERT(a_halt_stopped, halted_r |-> !running_r, "halted while still running")
  `LMCS_ASSERT(a_col_range, !halted_r |-> (col_r < COL_W'(COLUMNS)), "scan column out of range")

endmodule

@@ hw/rtl/lmcs_fifo.sv @@
module lmcs_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  lmcs_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output lmcs_pkg::result_t   out_res
);
  import lmcs_pkg::*;

  result_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic                    pop;

  // Room for the largest burst one item can produce
  assign room      = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    count_nxt  = count_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Up to three entries written in consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (k < int'(push.count)) begin
        mem_r[wr_ptr_r + FIFO_PTR_W'(k)] <= push.res[k];
      end
    end
  end

`include "led_matrix_column_scanner_macros.svh"

  `LMCS_ASSERT_NEVER(a_fifo_count, count_r > FIFO_CNT_W'(FIFO_DEPTH), "result queue over depth")
  `LMCS_ASSERT_NEVER(a_fifo_push, (push.count != 2'd0) && !room, "push without room")

endmodule

@@ hw/rtl/led_matrix_column_scanner.sv @@
// Flow: an accepted item waits in the input register until the queue has room for a full
//   burst; its results are then written into the queue and presented on out_* from there.
// Throughput: one item per cycle, and results leave an 8-deep queue one per cycle unless
//   out_stall is high; input stalls while an item waits with fewer than three slots free.
// Reset (rst_n low, synchronous): frame store cleared, delay 11, step 10, minimum 1.
module led_matrix_column_scanner (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_port_write,
  output logic [7:0] out_port_byte,
  output logic       out_frame_done,
  output logic       out_load_refused,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [9:0] cfg_wdata
);
  import lmcs_pkg::*;

  logic    stage_valid_r, stage_valid_nxt;
  item_t   stage_item_r;
  logic    room;
  logic    go;
  logic    in_take;
  push_t   push;
  result_t out_res;

  // Input register advances whenever the queue can take a full burst
  assign go       = stage_valid_r && room;
  assign in_stall = stage_valid_r && !room;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_take) begin
      stage_valid_nxt = 1'b1;
    end else if (go) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_item_r <= '{operation: in_operation, data_byte: in_data_byte,
                        last_byte: in_last_byte};
    end
  end

  lmcs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (stage_item_r),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  lmcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_port_write   = out_res.port_write;
  assign out_port_byte    = out_res.port_byte;
  assign out_frame_done   = out_res.frame_done;
  assign out_load_refused = out_res.load_refused;
  assign out_last         = out_res.last;

endmodule
